[sv/run_length_blob_detector_defines.svh]
// Assertion macros for the run-length blob detector.
// Used by the top level; needs clk_i and rst_ni in the including scope.
`ifndef RUN_LENGTH_BLOB_DETECTOR_DEFINES_SVH
`define RUN_LENGTH_BLOB_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RLBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("blob detector assertion failed");
`define RLBD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("blob detector condition must not occur");
`else
`define RLBD_ASSERT(lbl, prop)
`define RLBD_ASSERT_NEVER(lbl, cond)
`endif
`endif

[sv/rlbd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the run-length blob detector.
// No dependencies.
package rlbd_pkg;

  localparam int X_W          = 10;
  localparam int WH_W         = 11;
  localparam int MAX_GAP_W    = 10;
  localparam int MIN_W        = 11;
  localparam int GAP_W        = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;
  localparam int RESULT_LIMIT = 16;
  localparam int ECNT_W       = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_GAP,
    CFG_MIN_SEG_W,
    CFG_MIN_BLOB_H
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEG_RD,
    ST_SEG_EV,
    ST_SEG_WR,
    ST_RET_RD,
    ST_RET_EV,
    ST_FIN_RD,
    ST_FIN_EV,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic pixel_match;
    logic row_end;
    logic frame_end;
  } in_item_t;

  typedef struct packed {
    logic [X_W-1:0]  blob_x;
    logic [X_W-1:0]  blob_y;
    logic [WH_W-1:0] blob_width;
    logic [WH_W-1:0] blob_height;
    logic            blob_valid;
    logic            frame_last;
    logic            table_overflow;
  } out_item_t;

endpackage

[sv/rlbd_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rlbd_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/run_length_blob_detector.sv]
`timescale 1ns / 1ps
// Run-length blob detector top level: run tracking, blob table walks, output.
// Depends on rlbd_pkg, rlbd_ram and run_length_blob_detector_defines.svh.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o  | in_item_i (in_item_t)
//   out     | output    | out_valid_o/out_ready_i| out_item_o (out_item_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A pixel inside a row is taken in ST_IDLE. A closed segment walks the blob table
// through the RAM read port (ST_SEG_RD, ST_SEG_EV per stored blob, then
// ST_SEG_WR). A row end walks the table once more (ST_RET_RD, ST_RET_EV), a
// frame end twice (also ST_FIN_RD, ST_FIN_EV); both end in ST_FLUSH. Results
// wait in a one-item hold and an output register; a stalled output freezes the
// walk. Reset is asynchronous; the table needs no clearing.
module run_length_blob_detector #(
  parameter int MAX_BLOBS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rlbd_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rlbd_pkg::out_item_t               out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rlbd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rlbd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import rlbd_pkg::*;
  `include "run_length_blob_detector_defines.svh"

  localparam int CW   = X_W;
  localparam int DW   = CW + 1;
  localparam int EW   = 2 * CW + 2 * DW;
  localparam int SW   = ((CW > MAX_GAP_W) ? CW : MAX_GAP_W) + 3;
  localparam int AW   = $clog2(MAX_BLOBS);
  localparam int CNTW = $clog2(MAX_BLOBS + 1);

  state_e state_q, state_d;
  logic [CNTW-1:0] j_q, j_d, wp_q, wp_d, mi_q, mi_d, count_q, count_d;
  logic found_q, found_d;
  logic [CW-1:0] mx_q, mx_d, my_q, my_d;
  logic [DW-1:0] mw_q, mw_d, mh_q, mh_d;
  logic [CW-1:0] s_q, s_d;
  logic [DW-1:0] e_q, e_d;
  logic rend_q, rend_d, fend_q, fend_d;
  logic [CW-1:0] col_q, col_d, row_q, row_d, rs_q, rs_d;
  logic inrun_q, inrun_d, ovf_q, ovf_d;
  logic [GAP_W-1:0] gap_q, gap_d;
  out_item_t hold_q, hold_d, out_q, out_d;
  logic hold_v_q, hold_v_d, out_v_q, out_v_d;
  logic [ECNT_W-1:0] ecnt_q, ecnt_d;
  logic [MAX_GAP_W-1:0] max_gap_q;
  logic [MIN_W-1:0] min_sw_q, min_bh_q;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  rlbd_ram #(.WIDTH(EW), .DEPTH(MAX_BLOBS)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [CW-1:0] bx, by;
  logic [DW-1:0] bw, bh;
  assign bx = ram_rdata[EW-1 -: CW];
  assign by = ram_rdata[EW-CW-1 -: CW];
  assign bw = ram_rdata[2*DW-1 -: DW];
  assign bh = ram_rdata[DW-1:0];

  logic out_free;
  assign out_free    = !out_v_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gap_q <= MAX_GAP_W'(2);
      min_sw_q  <= MIN_W'(3);
      min_bh_q  <= MIN_W'(3);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_GAP:    max_gap_q <= cfg_data_i[MAX_GAP_W-1:0];
        CFG_MIN_SEG_W:  min_sw_q  <= cfg_data_i[MIN_W-1:0];
        CFG_MIN_BLOB_H: min_bh_q  <= cfg_data_i[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] ov_right, ov_e, ov_s, ov_bx, m_right, ret_sum;
  logic ov;
  logic emit_req, stall;
  out_item_t emit_item;

  always_comb begin
    ov_s     = SW'(s_q);
    ov_e     = SW'(e_q);
    ov_bx    = SW'(bx);
    ov_right = SW'(bx) + SW'(bw);
    ov       = (ov_s <= ov_bx) ? (ov_e > ov_bx) : (ov_s <= ov_right);
    ret_sum  = SW'(by) + SW'(bh) + SW'(max_gap_q);
    m_right  = SW'(mx_q) + SW'(mw_q);

    emit_item                = '0;
    emit_item.blob_x         = X_W'(bx);
    emit_item.blob_y         = X_W'(by);
    emit_item.blob_width     = WH_W'(bw);
    emit_item.blob_height    = WH_W'(bh);
    emit_item.blob_valid     = 1'b1;
    emit_req = ((state_q == ST_RET_EV) && (ret_sum < SW'(row_q)) && (bh > min_bh_q)) ||
               (state_q == ST_FIN_EV);
    stall = emit_req && (ecnt_q < ECNT_W'(RESULT_LIMIT)) && hold_v_q && !out_free;
  end

  logic [GAP_W-1:0] g_new;
  logic [CW-1:0] rs_cur;
  logic [SW-1:0] end_v, seg_wd, right_v;
  logic close_now, seg_go;
  logic [CW-1:0] nx;

  always_comb begin
    state_d  = state_q;
    j_d      = j_q;
    wp_d     = wp_q;
    mi_d     = mi_q;
    count_d  = count_q;
    found_d  = found_q;
    mx_d     = mx_q;
    my_d     = my_q;
    mw_d     = mw_q;
    mh_d     = mh_q;
    s_d      = s_q;
    e_d      = e_q;
    rend_d   = rend_q;
    fend_d   = fend_q;
    col_d    = col_q;
    row_d    = row_q;
    rs_d     = rs_q;
    inrun_d  = inrun_q;
    gap_d    = gap_q;
    ovf_d    = ovf_q;
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !out_ready_i;
    ecnt_d   = ecnt_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = wp_q[AW-1:0];
    ram_raddr = j_q[AW-1:0];
    ram_wdata = ram_rdata;
    g_new     = gap_q;
    rs_cur    = rs_q;
    end_v     = '0;
    seg_wd    = '0;
    right_v   = '0;
    close_now = 1'b0;
    seg_go    = 1'b0;
    nx        = mx_q;

    if (emit_req && !stall && (ecnt_q < ECNT_W'(RESULT_LIMIT))) begin
      if (hold_v_q) begin
        out_d   = hold_q;
        out_v_d = 1'b1;
      end
      hold_d   = emit_item;
      hold_v_d = 1'b1;
      ecnt_d   = ecnt_q + 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ecnt_d = '0;
          rend_d = in_item_i.row_end;
          fend_d = in_item_i.frame_end;
          inrun_d = inrun_q;
          if (in_item_i.pixel_match) begin
            if (!inrun_q) begin
              inrun_d = 1'b1;
              rs_cur  = col_q;
            end
            g_new = '0;
          end else if (inrun_q) begin
            g_new = (gap_q < {GAP_W{1'b1}}) ? gap_q + 1'b1 : gap_q;
            if (g_new > GAP_W'(max_gap_q)) begin
              close_now = 1'b1;
              end_v     = SW'(col_q) - SW'(max_gap_q);
              inrun_d   = 1'b0;
            end
          end
          if (!close_now && inrun_d && (in_item_i.row_end || in_item_i.frame_end)) begin
            close_now = 1'b1;
            end_v     = SW'(col_q) + SW'(1) - SW'(g_new);
          end
          if (close_now) begin
            if ($signed(end_v) < $signed(SW'(rs_cur))) begin
              end_v = SW'(rs_cur);
            end
            seg_wd = end_v - SW'(rs_cur);
            seg_go = (seg_wd >= SW'(min_sw_q));
            inrun_d = 1'b0;
          end
          s_d = rs_cur;
          e_d = DW'(end_v);
          j_d = '0;
          wp_d = '0;
          found_d = 1'b0;
          if (!in_item_i.row_end && !in_item_i.frame_end) begin
            col_d   = (col_q < {CW{1'b1}}) ? col_q + 1'b1 : col_q;
            rs_d    = rs_cur;
            gap_d   = g_new;
          end else begin
            col_d   = '0;
            rs_d    = '0;
            gap_d   = '0;
            inrun_d = 1'b0;
          end
          if (seg_go) begin
            state_d = ST_SEG_RD;
          end else if (in_item_i.row_end || in_item_i.frame_end) begin
            state_d = ST_RET_RD;
          end
        end
      end
      ST_SEG_RD: begin
        if (j_q == count_q) begin
          state_d = ST_SEG_WR;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_SEG_EV;
        end
      end
      ST_SEG_EV: begin
        j_d     = j_q + 1'b1;
        state_d = ST_SEG_RD;
        if (ov && !found_q) begin
          found_d = 1'b1;
          mi_d    = wp_q;
          wp_d    = wp_q + 1'b1;
          right_v = (ov_right > ov_e) ? ov_right : ov_e;
          nx      = (s_q < bx) ? s_q : bx;
          mx_d    = nx;
          my_d    = by;
          mw_d    = DW'(right_v - SW'(nx));
          mh_d    = DW'(row_q) - DW'(by) + DW'(1);
        end else if (ov) begin
          if (m_right < ov_right) begin
            mw_d = DW'(ov_right - SW'(mx_q));
          end
        end else begin
          ram_we = 1'b1;
          wp_d   = wp_q + 1'b1;
        end
      end
      ST_SEG_WR: begin
        if (found_q) begin
          ram_we    = 1'b1;
          ram_waddr = mi_q[AW-1:0];
          ram_wdata = {mx_q, my_q, mw_q, mh_q};
          count_d   = wp_q;
        end else if (count_q < CNTW'(MAX_BLOBS)) begin
          ram_we    = 1'b1;
          ram_waddr = count_q[AW-1:0];
          ram_wdata = {s_q, row_q, DW'(e_q) - DW'(s_q), DW'(1)};
          count_d   = count_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
        j_d  = '0;
        wp_d = '0;
        state_d = (rend_q || fend_q) ? ST_RET_RD : ST_IDLE;
      end
      ST_RET_RD: begin
        if (j_q == count_q) begin
          count_d = wp_q;
          j_d     = '0;
          state_d = fend_q ? ST_FIN_RD : ST_FLUSH;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_RET_EV;
        end
      end
      ST_RET_EV: begin
        if (!stall) begin
          j_d     = j_q + 1'b1;
          state_d = ST_RET_RD;
          if (!(ret_sum < SW'(row_q))) begin
            ram_we = 1'b1;
            wp_d   = wp_q + 1'b1;
          end
        end
      end
      ST_FIN_RD: begin
        if (j_q == count_q) begin
          state_d = ST_FLUSH;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_FIN_EV;
        end
      end
      ST_FIN_EV: begin
        if (!stall) begin
          j_d     = j_q + 1'b1;
          state_d = ST_FIN_RD;
        end
      end
      ST_FLUSH: begin
        if (fend_q) begin
          if (out_free) begin
            out_d   = hold_v_q ? hold_q : out_item_t'('0);
            out_d.frame_last     = 1'b1;
            out_d.table_overflow = ovf_q;
            out_v_d  = 1'b1;
            hold_v_d = 1'b0;
            count_d  = '0;
            row_d    = '0;
            ovf_d    = 1'b0;
            state_d  = ST_IDLE;
          end
        end else if (!hold_v_q || out_free) begin
          if (hold_v_q) begin
            out_d   = hold_q;
            out_v_d = 1'b1;
          end
          hold_v_d = 1'b0;
          row_d    = (row_q < {CW{1'b1}}) ? row_q + 1'b1 : row_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      j_q      <= '0;
      wp_q     <= '0;
      mi_q     <= '0;
      count_q  <= '0;
      found_q  <= 1'b0;
      rend_q   <= 1'b0;
      fend_q   <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      rs_q     <= '0;
      inrun_q  <= 1'b0;
      gap_q    <= '0;
      ovf_q    <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      ecnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      j_q      <= j_d;
      wp_q     <= wp_d;
      mi_q     <= mi_d;
      count_q  <= count_d;
      found_q  <= found_d;
      rend_q   <= rend_d;
      fend_q   <= fend_d;
      col_q    <= col_d;
      row_q    <= row_d;
      rs_q     <= rs_d;
      inrun_q  <= inrun_d;
      gap_q    <= gap_d;
      ovf_q    <= ovf_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
      ecnt_q   <= ecnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q   <= mx_d;
    my_q   <= my_d;
    mw_q   <= mw_d;
    mh_q   <= mh_d;
    s_q    <= s_d;
    e_q    <= e_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  `RLBD_ASSERT(a_count_bound, count_q <= CNTW'(MAX_BLOBS))
  `RLBD_ASSERT(a_wp_behind, (state_q == ST_SEG_EV || state_q == ST_RET_EV) |-> wp_q <= j_q)
  `RLBD_ASSERT(a_hold_counted, hold_v_q |-> ecnt_q != '0)
  `RLBD_ASSERT_NEVER(a_emit_limit, ecnt_q > ECNT_W'(RESULT_LIMIT))

endmodule
